@@ rtl/sclane_pkg.sv @@
// sclane_pkg: shared types and constants of the comment lane allocator.
// Used by every module of the block except sclane_ram; depends on nothing.
`default_nettype none

package sclane_pkg;

  // Field widths of the input and result words
  localparam int unsigned TIME_W     = 31;
  localparam int unsigned TEXT_W     = 16;
  localparam int unsigned PLACE_W    = 2;
  localparam int unsigned LANE_IDX_W = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WWIDTH_W   = 16;
  localparam int unsigned LCOUNT_W   = 6;
  localparam int unsigned SPAN_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_SPAN    = 2'd2;

  localparam logic [WWIDTH_W-1:0] WWIDTH_RST = 16'd1280;
  localparam logic [LCOUNT_W-1:0] LCOUNT_RST = 6'd12;
  localparam logic [SPAN_W-1:0]   SPAN_RST   = 16'd400;

  // Placement codes (top and the unused code scroll like placement 0)
  localparam logic [PLACE_W-1:0] PLACE_SCROLL = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_BOTTOM = 2'd1;

  // Lane default and entry margin in 10 ms units
  localparam int unsigned MAX_LANES_DEF = 32;
  localparam logic [31:0] ENTRY_MARGIN  = 32'd10;

  // Shared divider: 32-bit dividend, 17-bit divisor, 16-bit quotient
  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DEN_W = 17;
  localparam int unsigned DIV_Q_W   = 16;
  localparam int unsigned DIV_STEP  = 4;

  typedef struct packed {
    logic [TIME_W-1:0]  arrival_time;
    logic [TEXT_W-1:0]  text_width;
    logic [PLACE_W-1:0] placement;
  } in_word_t;

  typedef struct packed {
    logic [LANE_IDX_W-1:0] lane_index;
    logic                  half_offset;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic mul_item;
    logic lane_load;
    logic div_start;
    logic cap_catch;
    logic lane_inc;
    logic fin_hit;
    logic fin_zero;
    logic fin_best;
    logic wr;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bottom;
    logic div_done;
    logic bot_hit;
    logic scr_hit;
    logic last_lane;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/scrolling_comment_lane_allocator_core.sv @@
// Comment lane allocator, top level: joins controller and datapath.
// Depends on sclane_pkg, sclane_ctrl, sclane_dpath (sclane_ram, sclane_div).
//
// Usage:
//   in_*  : one comment word (time, text width, placement) per handshake.
//   out_* : one result word (lane index, half-lane flag) per comment, in order.
//   cfg_* : register writes (window width, lane count, lane span); always
//           ready, to be written only while no comment is in flight.
// One comment is processed at a time. Up to the active lane count of lanes
// are examined, and the result is loaded into the output register after the
// scan. Each lane test goes through a lane store read, and each scrolling
// lane test also through the shared divider (four quotient bits a cycle),
// which a scrolling comment first uses for its own catch-up share. in_ready
// rises again the cycle after the result is loaded. A held result stalls only
// the final hand-off: the next comment is accepted while it waits.
// Reset (rst_n, synchronous) restores register defaults and marks all lane
// entries empty through valid bits, so no clearing pass is needed.
`default_nettype none

module scrolling_comment_lane_allocator_core #(
  parameter int unsigned MAX_LANES = sclane_pkg::MAX_LANES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire sclane_pkg::in_word_t                  in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output sclane_pkg::out_word_t                      out_data,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [sclane_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sclane_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sclane_pkg::cmd_t cmd;
  sclane_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  sclane_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sclane_dpath #(.MAX_LANES(MAX_LANES)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/sclane_ram.sv @@
// sclane_ram: generic single write port, single read port RAM with
// registered read data. No dependencies.
`default_nettype none

module sclane_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/sclane_div.sv @@
// sclane_div: iterative restoring divider, four quotient bits a cycle.
// Depends on sclane_pkg for its widths. Zero divisor gives quotient 0.
`default_nettype none

module sclane_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [sclane_pkg::DIV_NUM_W-1:0]     num,
  input  wire logic [sclane_pkg::DIV_DEN_W-1:0]     den,
  output logic                                      done,
  output logic      [sclane_pkg::DIV_Q_W-1:0]       quot
);

  localparam int unsigned NW    = sclane_pkg::DIV_NUM_W;
  localparam int unsigned DW    = sclane_pkg::DIV_DEN_W;
  localparam int unsigned QW    = sclane_pkg::DIV_Q_W;
  localparam int unsigned STEP  = sclane_pkg::DIV_STEP;
  localparam int unsigned ITERS = QW / STEP;
  localparam int unsigned CW    = (ITERS > 1) ? $clog2(ITERS) : 1;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] lo_r, lo_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [DW-1:0] den_r;
  logic          zero_r;
  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;

  // STEP dependent compare-subtract steps; remainder stays below divisor
  always_comb begin
    logic [DW:0] trial;
    logic        qbit;
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    q_nxt   = q_r;
    for (int i = 0; i < STEP; i++) begin
      trial  = {rem_nxt, lo_nxt[QW-1]};
      lo_nxt = {lo_nxt[QW-2:0], 1'b0};
      qbit   = 1'b0;
      if (trial >= {1'b0, den_r}) begin
        trial = trial - {1'b0, den_r};
        qbit  = 1'b1;
      end
      rem_nxt = trial[DW-1:0];
      q_nxt   = {q_nxt[QW-2:0], qbit};
    end
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= DW'(num[NW-1:QW]);
      lo_r   <= num[QW-1:0];
      den_r  <= den;
      zero_r <= (den == '0);
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = zero_r ? '0 : q_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");
`endif

endmodule

`default_nettype wire

@@ rtl/sclane_dpath.sv @@
// sclane_dpath: configuration registers, lane stores, scan datapath,
// shared divider and result register. Depends on sclane_pkg, sclane_ram
// and sclane_div; driven by sclane_ctrl through cmd_t / sts_t.
`default_nettype none

module sclane_dpath #(
  parameter int unsigned MAX_LANES = sclane_pkg::MAX_LANES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire sclane_pkg::in_word_t                  in_data,
  input  wire logic                                  cfg_valid,
  input  wire logic [sclane_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sclane_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire sclane_pkg::cmd_t                      cmd,
  output sclane_pkg::sts_t                           sts,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output sclane_pkg::out_word_t                      out_data
);

  localparam int unsigned LW  = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int unsigned TW  = sclane_pkg::TIME_W;
  localparam int unsigned XW  = sclane_pkg::TEXT_W;
  localparam int unsigned SW  = sclane_pkg::SPAN_W;
  localparam int unsigned CNW = sclane_pkg::LCOUNT_W;
  localparam int unsigned QW  = sclane_pkg::DIV_Q_W;
  localparam int unsigned NW  = sclane_pkg::DIV_NUM_W;
  localparam int unsigned DW  = sclane_pkg::DIV_DEN_W;

  // Configuration
  logic [sclane_pkg::WWIDTH_W-1:0] ww_r;
  logic [CNW-1:0]                  lc_r;
  logic [SW-1:0]                   span_r;

  // Item and scan state
  logic [TW-1:0]     t_r;
  logic [XW-1:0]     w_r;
  logic              bot_r;
  logic [LW-1:0]     nlast_r, nlast_nxt;
  logic [LW-1:0]     j_r;
  logic [LW-1:0]     best_r;
  logic [TW-1:0]     best_t_r;
  logic [TW:0]       catch_r;
  logic [NW-1:0]     num_r;
  logic [DW-1:0]     den_r;
  logic [TW-1:0]     pt_r;
  logic [LW-1:0]     res_lane_r;
  logic              res_half_r;
  logic [MAX_LANES-1:0] sv_r;
  logic [MAX_LANES-1:0] bv_r;
  logic              vld_r;
  logic              out_vld_r;
  sclane_pkg::out_word_t out_data_r;

  logic [TW+XW-1:0]  s_rdata;
  logic [TW-1:0]     b_rdata;
  logic [TW-1:0]     s_time, b_time;
  logic [XW-1:0]     s_width;
  logic [CNW-1:0]    lc_m1;
  logic              div_done;
  logic [QW-1:0]     quot;
  logic [TW:0]       bot_lhs, scr_lhs1, scr_lhs2;
  logic              scr_skip;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ww_r   <= sclane_pkg::WWIDTH_RST;
      lc_r   <= sclane_pkg::LCOUNT_RST;
      span_r <= sclane_pkg::SPAN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sclane_pkg::CFG_WINDOW_WIDTH: ww_r   <= cfg_data;
        sclane_pkg::CFG_LANE_COUNT:   lc_r   <= cfg_data[CNW-1:0];
        sclane_pkg::CFG_LANE_SPAN:    span_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Last active lane: zero count acts as one lane, large counts saturate
  assign lc_m1 = lc_r - 1'b1;

  always_comb begin
    if (lc_r == '0) begin
      nlast_nxt = '0;
    end else if (32'(lc_r) > MAX_LANES) begin
      nlast_nxt = LW'(MAX_LANES - 1);
    end else begin
      nlast_nxt = LW'(lc_m1);
    end
  end

  // Lane stores; entries never written read as zero via valid bits
  sclane_ram #(.WIDTH(TW + XW), .DEPTH(MAX_LANES)) u_scroll_ram (
    .clk   (clk),
    .we    (cmd.wr && !bot_r),
    .waddr (res_lane_r),
    .wdata ({t_r, w_r}),
    .raddr (j_r),
    .rdata (s_rdata)
  );

  sclane_ram #(.WIDTH(TW), .DEPTH(MAX_LANES)) u_bottom_ram (
    .clk   (clk),
    .we    (cmd.wr && bot_r),
    .waddr (res_lane_r),
    .wdata (t_r),
    .raddr (j_r),
    .rdata (b_rdata)
  );

  assign s_time  = vld_r ? s_rdata[TW+XW-1:XW] : '0;
  assign s_width = vld_r ? s_rdata[XW-1:0]     : '0;
  assign b_time  = vld_r ? b_rdata             : '0;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      bv_r <= '0;
    end else if (cmd.wr) begin
      if (bot_r) begin
        bv_r[res_lane_r] <= 1'b1;
      end else begin
        sv_r[res_lane_r] <= 1'b1;
      end
    end
  end

  // Valid flag travels with the registered read data
  always_ff @(posedge clk) begin
    vld_r <= bot_r ? bv_r[j_r] : sv_r[j_r];
  end

  // Shared divider for both scroll shares
  sclane_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  // Item capture, operand products, lane scan
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      t_r     <= in_data.arrival_time;
      w_r     <= in_data.text_width;
      bot_r   <= (in_data.placement == sclane_pkg::PLACE_BOTTOM);
      nlast_r <= nlast_nxt;
    end
    if (cmd.mul_item) begin
      num_r <= {16'b0, span_r} * {16'b0, ww_r};
      den_r <= {1'b0, ww_r} + {1'b0, w_r};
    end
    if (cmd.lane_load) begin
      num_r <= {16'b0, span_r} * {16'b0, s_width};
      den_r <= {1'b0, ww_r} + {1'b0, s_width};
      pt_r  <= s_time;
      // oldest occupant, lowest index on ties
      if (j_r == '0 || s_time < best_t_r) begin
        best_r   <= j_r;
        best_t_r <= s_time;
      end
    end
    if (cmd.cap_catch) begin
      catch_r <= {1'b0, t_r} + (TW+1)'(quot);
    end
    if (cmd.load_item) begin
      j_r <= '0;
    end else if (cmd.lane_inc) begin
      j_r <= j_r + 1'b1;
    end
    if (cmd.fin_hit) begin
      res_lane_r <= j_r;
      res_half_r <= 1'b0;
    end else if (cmd.fin_zero) begin
      res_lane_r <= '0;
      res_half_r <= 1'b0;
    end else if (cmd.fin_best) begin
      res_lane_r <= best_r;
      res_half_r <= 1'b1;
    end
  end

  // Lane tests
  assign bot_lhs  = {1'b0, b_time} + (TW+1)'(span_r);
  assign scr_lhs1 = {1'b0, pt_r} + (TW+1)'(sclane_pkg::ENTRY_MARGIN) + (TW+1)'(quot);
  assign scr_lhs2 = {1'b0, pt_r} + (TW+1)'(sclane_pkg::ENTRY_MARGIN) + (TW+1)'(span_r);
  assign scr_skip = scr_lhs1 > {1'b0, t_r};

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.lane_index  <= sclane_pkg::LANE_IDX_W'(res_lane_r);
      out_data_r.half_offset <= res_half_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Status
  always_comb begin
    sts.bottom    = bot_r;
    sts.div_done  = div_done;
    sts.bot_hit   = bot_lhs < {1'b0, t_r};
    sts.scr_hit   = !scr_skip && (scr_lhs2 < catch_r);
    sts.last_lane = (j_r == nlast_r);
    sts.out_free  = !out_vld_r || out_ready;
  end

`ifndef SYNTH
  a_lane_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> res_lane_r <= nlast_r)
    else $error("chosen lane beyond active lanes");

  a_bottom_no_half: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && bot_r |-> !res_half_r)
    else $error("half offset on a bottom comment");
`endif

endmodule

`default_nettype wire

@@ rtl/sclane_ctrl.sv @@
// sclane_ctrl: state machine sequencing one comment through dispatch,
// lane scan, store update and result hand-off. Depends on sclane_pkg.
`default_nettype none

module sclane_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sclane_pkg::sts_t   sts,
  output sclane_pkg::cmd_t        cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DISP  = 4'd1;
  localparam logic [3:0] ST_IDIV  = 4'd2;
  localparam logic [3:0] ST_IWAIT = 4'd3;
  localparam logic [3:0] ST_SRD   = 4'd4;
  localparam logic [3:0] ST_SLD   = 4'd5;
  localparam logic [3:0] ST_SDIV  = 4'd6;
  localparam logic [3:0] ST_SWAIT = 4'd7;
  localparam logic [3:0] ST_BRD   = 4'd8;
  localparam logic [3:0] ST_BCHK  = 4'd9;
  localparam logic [3:0] ST_WR    = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DISP;
        end
      end
      ST_DISP: begin
        if (sts.bottom) begin
          state_nxt = ST_BRD;
        end else begin
          cmd.mul_item = 1'b1;
          state_nxt    = ST_IDIV;
        end
      end
      ST_IDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_IWAIT;
      end
      ST_IWAIT: begin
        if (sts.div_done) begin
          cmd.cap_catch = 1'b1;
          state_nxt     = ST_SRD;
        end
      end
      ST_SRD: begin
        state_nxt = ST_SLD;
      end
      ST_SLD: begin
        cmd.lane_load = 1'b1;
        state_nxt     = ST_SDIV;
      end
      ST_SDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (sts.div_done) begin
          if (sts.scr_hit) begin
            cmd.fin_hit = 1'b1;
            state_nxt   = ST_WR;
          end else if (sts.last_lane) begin
            cmd.fin_best = 1'b1;
            state_nxt    = ST_WR;
          end else begin
            cmd.lane_inc = 1'b1;
            state_nxt    = ST_SRD;
          end
        end
      end
      ST_BRD: begin
        state_nxt = ST_BCHK;
      end
      ST_BCHK: begin
        if (sts.bot_hit) begin
          cmd.fin_hit = 1'b1;
          state_nxt   = ST_WR;
        end else if (sts.last_lane) begin
          cmd.fin_zero = 1'b1;
          state_nxt    = ST_WR;
        end else begin
          cmd.lane_inc = 1'b1;
          state_nxt    = ST_BRD;
        end
      end
      ST_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the comment lane allocator core.
// Depends on sclane_pkg and scrolling_comment_lane_allocator_core; drives random
// comment words under several register settings and checks each lane word.
`timescale 1ns / 1ps

module testbench;

  // Placement codes that the package leaves unnamed, and the spare register index
  localparam logic [sclane_pkg::PLACE_W-1:0]   PLACE_TOP   = 2'd2;
  localparam logic [sclane_pkg::PLACE_W-1:0]   PLACE_SPARE = 2'd3;
  localparam logic [sclane_pkg::CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam logic [sclane_pkg::TIME_W-1:0]    TIME_MAX    = 31'h7fffffff;
  localparam int unsigned                      LONG_HOLD   = 400;
  localparam int unsigned                      SETTLE      = 300;

  // Tracks lane occupancy and holds the lane words still owed by the block
  class lane_allocation_tracker;
    logic [sclane_pkg::WWIDTH_W-1:0] window_width;
    logic [sclane_pkg::LCOUNT_W-1:0] lane_count;
    logic [sclane_pkg::SPAN_W-1:0]   lane_span;
    logic [sclane_pkg::TIME_W-1:0]   scroll_time [sclane_pkg::MAX_LANES_DEF];
    logic [sclane_pkg::TEXT_W-1:0]   scroll_width [sclane_pkg::MAX_LANES_DEF];
    logic [sclane_pkg::TIME_W-1:0]   bottom_time [sclane_pkg::MAX_LANES_DEF];
    sclane_pkg::out_word_t           expected_lanes [$];
    int unsigned                     mismatches;

    function new();
      window_width = sclane_pkg::WWIDTH_RST;
      lane_count   = sclane_pkg::LCOUNT_RST;
      lane_span    = sclane_pkg::SPAN_RST;
      mismatches   = 0;
      for (int i = 0; i < sclane_pkg::MAX_LANES_DEF; i++) begin
        scroll_time[i]  = '0;
        scroll_width[i] = '0;
        bottom_time[i]  = '0;
      end
    endfunction

    function void write_register(logic [sclane_pkg::CFG_IDX_W-1:0] idx,
                                 logic [sclane_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sclane_pkg::CFG_WINDOW_WIDTH: window_width = data[sclane_pkg::WWIDTH_W-1:0];
        sclane_pkg::CFG_LANE_COUNT:   lane_count   = data[sclane_pkg::LCOUNT_W-1:0];
        sclane_pkg::CFG_LANE_SPAN:    lane_span    = data[sclane_pkg::SPAN_W-1:0];
        default: ;
      endcase
    endfunction

    // span * num / (window + other), zero when the divisor is zero
    function longint unsigned span_share(longint unsigned num, longint unsigned other);
      longint unsigned divisor;
      divisor = window_width;
      divisor = divisor + other;
      if (divisor == 0) return 0;
      return (lane_span * num) / divisor;
    endfunction

    // Place one accepted comment and queue the lane word it must produce
    function void note_comment(sclane_pkg::in_word_t c);
      longint unsigned       t, catch_up, prev, pw;
      int unsigned           n, j;
      bit                    found, half;
      sclane_pkg::out_word_t want;
      t     = c.arrival_time;
      n     = (lane_count == 0) ? 1 :
              ((lane_count > sclane_pkg::MAX_LANES_DEF) ? sclane_pkg::MAX_LANES_DEF :
               lane_count);
      j     = 0;
      found = 1'b0;
      half  = 1'b0;
      if (c.placement == sclane_pkg::PLACE_BOTTOM) begin
        // first bottom lane whose occupant is older than the span
        while (j < n && !found) begin
          prev = bottom_time[j];
          if (prev + lane_span < t) found = 1'b1;
          else j++;
        end
        if (!found) j = 0;
        bottom_time[j] = c.arrival_time;
      end else begin
        // first lane fully entered and not caught up with
        catch_up = t + span_share(window_width, c.text_width);
        while (j < n && !found) begin
          prev = scroll_time[j];
          pw   = scroll_width[j];
          if (prev + sclane_pkg::ENTRY_MARGIN + span_share(pw, pw) <= t &&
              prev + sclane_pkg::ENTRY_MARGIN + lane_span < catch_up) found = 1'b1;
          else j++;
        end
        // none free: oldest occupant, lowest index on ties, shifted half a lane
        if (!found) begin
          j = 0;
          for (int k = 1; k < n; k++)
            if (scroll_time[k] < scroll_time[j]) j = k;
          half = 1'b1;
        end
        scroll_time[j]  = c.arrival_time;
        scroll_width[j] = c.text_width;
      end
      want.lane_index  = j[sclane_pkg::LANE_IDX_W-1:0];
      want.half_offset = half;
      expected_lanes   = {expected_lanes, want};
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_lane_word(sclane_pkg::out_word_t got);
      sclane_pkg::out_word_t want;
      if (expected_lanes.size() == 0) begin
        report_mismatch($sformatf("unexpected word lane %0d half %0b",
                                  got.lane_index, got.half_offset));
        return;
      end
      want = expected_lanes.pop_front();
      if (got.lane_index !== want.lane_index)
        report_mismatch($sformatf("lane_index %0d, expected %0d",
                                  got.lane_index, want.lane_index));
      if (got.half_offset !== want.half_offset)
        report_mismatch($sformatf("half_offset %0b, expected %0b",
                                  got.half_offset, want.half_offset));
    endtask
  endclass

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  sclane_pkg::in_word_t              in_data   = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  sclane_pkg::out_word_t             out_data;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [sclane_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sclane_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  lane_allocation_tracker tracker = new();
  bit                     steady;
  bit                     hold_off_req;
  longint unsigned        arrival_clock;

  scrolling_comment_lane_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Handshake monitors: sampled values are the ones held before the edge
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) tracker.write_register(cfg_index, cfg_data);
    if (rst_n && in_valid && in_ready) tracker.note_comment(in_data);
    if (rst_n && out_valid && out_ready) tracker.check_lane_word(out_data);
  end

  // Result side: random stall per word, plus one long hold-off on request
  initial begin
    int unsigned gap;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one comment word; valid is left high for a back-to-back successor
  task automatic send_comment(input sclane_pkg::in_word_t c);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic sclane_pkg::in_word_t comment_word(
      input longint unsigned t, input int unsigned w,
      input logic [sclane_pkg::PLACE_W-1:0] p);
    sclane_pkg::in_word_t c;
    c.arrival_time = t[sclane_pkg::TIME_W-1:0];
    c.text_width   = w[sclane_pkg::TEXT_W-1:0];
    c.placement    = p;
    return c;
  endfunction

  // Mostly a rising time line at rates around the span, some raw noise
  function automatic sclane_pkg::in_word_t next_comment();
    int unsigned                    span, advance, w, roll;
    logic [31:0]                    rnd, rnd_place;
    logic [sclane_pkg::PLACE_W-1:0] p;
    span = tracker.lane_span;
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 3))
        0:       advance = $urandom_range(0, span / 64 + 2);
        1:       advance = $urandom_range(0, span / 8 + 10);
        2:       advance = $urandom_range(0, span / 2 + 20);
        default: advance = $urandom_range(span / 2, 2 * span + 40);
      endcase
      arrival_clock = arrival_clock + advance;
      if (arrival_clock > TIME_MAX - 200000) arrival_clock = $urandom_range(0, 1000);
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = $urandom_range(0, 65535);
        default: w = $urandom_range(1, 1500);
      endcase
      roll = $urandom_range(0, 19);
      if (roll < 12)      p = sclane_pkg::PLACE_SCROLL;
      else if (roll < 17) p = sclane_pkg::PLACE_BOTTOM;
      else if (roll < 19) p = PLACE_TOP;
      else                p = PLACE_SPARE;
      return comment_word(arrival_clock, w, p);
    end
    rnd       = $urandom();
    rnd_place = $urandom();
    return comment_word(64'(rnd[sclane_pkg::TIME_W-1:0]), $urandom_range(0, 65535),
                        rnd_place[sclane_pkg::PLACE_W-1:0]);
  endfunction

  task automatic run_random(input int unsigned count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == hold_at) hold_off_req = 1'b1;
      send_comment(next_comment());
    end
  endtask

  // Let every owed lane word come back; the block is idle afterwards
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_lanes.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [sclane_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sclane_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [sclane_pkg::CFG_DATA_W-1:0] ww,
                               input logic [sclane_pkg::CFG_DATA_W-1:0] lanes,
                               input logic [sclane_pkg::CFG_DATA_W-1:0] span,
                               input bit poke_spare);
    cfg_write(sclane_pkg::CFG_WINDOW_WIDTH, ww);
    cfg_write(sclane_pkg::CFG_LANE_COUNT, lanes);
    cfg_write(sclane_pkg::CFG_LANE_SPAN, span);
    if (poke_spare) cfg_write(CFG_SPARE, 16'hffff);
    cfg_valid <= 1'b0;
    arrival_clock = $urandom_range(0, 5000);
  endtask

  initial begin
    steady        = 1'b0;
    hold_off_req  = 1'b0;
    arrival_clock = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty lanes, bottom reuse, all placements, extreme fields
    send_comment(comment_word(0, 0, sclane_pkg::PLACE_SCROLL));
    send_comment(comment_word(0, 0, sclane_pkg::PLACE_BOTTOM));
    send_comment(comment_word(500, 100, sclane_pkg::PLACE_BOTTOM));
    send_comment(comment_word(500, 100, sclane_pkg::PLACE_BOTTOM));
    send_comment(comment_word(1000, 65535, sclane_pkg::PLACE_SCROLL));
    send_comment(comment_word(1000, 200, PLACE_TOP));
    send_comment(comment_word(1000, 200, PLACE_SPARE));
    send_comment(comment_word(1300, 0, sclane_pkg::PLACE_SCROLL));
    send_comment(comment_word(2000, 640, sclane_pkg::PLACE_SCROLL));
    send_comment(comment_word(2300, 1280, sclane_pkg::PLACE_SCROLL));
    send_comment(comment_word(TIME_MAX, 65535, sclane_pkg::PLACE_SCROLL));
    send_comment(comment_word(TIME_MAX, 0, sclane_pkg::PLACE_BOTTOM));
    send_comment(comment_word(TIME_MAX, 65535, PLACE_TOP));
    send_comment(comment_word(0, 65535, PLACE_SPARE));
    // a burst at one time fills the lanes
    for (int i = 0; i < 8; i++)
      send_comment(comment_word(3000, 300, sclane_pkg::PLACE_SCROLL));
    arrival_clock = 4000;
    run_random(200, -1);

    // Register settings, extremes first
    drain();
    apply_setting(16'd1, 16'd1, 16'd1, 1'b0);
    run_random(150, -1);
    drain();
    apply_setting(16'd65535, 16'd32, 16'd65535, 1'b0);
    run_random(200, -1);
    drain();
    // zero window: zero divisor on empty lanes; zero lanes act as one
    apply_setting(16'd0, 16'd0, 16'd300, 1'b0);
    run_random(150, -1);
    drain();
    // oversize lane count saturates; long result hold-off mid phase
    apply_setting(16'd640, 16'hffff, 16'd150, 1'b1);
    run_random(200, 100);
    drain();
    apply_setting(16'd1920, 16'd5, 16'd500, 1'b0);
    run_random(200, -1);
    drain();
    apply_setting(16'd65535, 16'd2, 16'd1, 1'b0);
    run_random(200, -1);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_lanes.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("testbench failed");
    $finish;
  end

endmodule
